// File: rtl/bcd_pkg.sv
// Shared types, codes and fixed-ratio divide helpers for the BC1/BC2/BC3 decoder.
// No dependencies; imported by every decoder module except bcd_checker.
package bcd_pkg;

    // Format register codes (code 3 decodes as BC1)
    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;
    localparam logic [1:0] FMT_BC3 = 2'd2;

    // How the alpha of a texel is produced
    localparam logic [1:0] ALPHA_NONE     = 2'd0;
    localparam logic [1:0] ALPHA_EXPLICIT = 2'd1;
    localparam logic [1:0] ALPHA_INTERP   = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam int unsigned LAST_TEXEL  = 15;

    // Classified block request, as held in the queue
    typedef struct packed {
        logic [63:0] colour_word;
        logic [63:0] alpha_word;
        logic [1:0]  alpha_mode;
    } bcd_entry_t;

    // Endpoints and palette numerators, one stage before the divides
    typedef struct packed {
        logic [2:0][7:0]  c0;
        logic [2:0][7:0]  c1;
        logic [2:0][9:0]  c2_num;
        logic [2:0][9:0]  c3_num;
        logic             four_col;
        logic [31:0]      col_idx;
        logic [1:0]       alpha_mode;
        logic [63:0]      alpha_word;
        logic [5:0][10:0] a_num;
        logic             eight_alpha;
    } bcd_num_t;

    // Finished palettes for one block
    typedef struct packed {
        logic [3:0][31:0] col_pal;
        logic [31:0]      col_idx;
        logic [1:0]       alpha_mode;
        logic [63:0]      alpha_word;
        logic [7:0][7:0]  alpha_pal;
    } bcd_pal_t;

    // RGB565 to 8-bit channels by bit replication, packed {b, g, r}
    function automatic logic [2:0][7:0] expand565(input logic [15:0] n);
        logic [2:0][7:0] c;
        c[0] = {n[15:11], n[15:13]};
        c[1] = {n[10:5], n[10:9]};
        c[2] = {n[4:0], n[4:2]};
        return c;
    endfunction

    // x / 3 for x < 768: reciprocal 683 / 2^11
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = {10'd0, x} * 20'd683;
        return p[18:11];
    endfunction

    // x / 7 for x < 1792: reciprocal 4682 / 2^15
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [23:0] p;
        p = {13'd0, x} * 24'd4682;
        return p[22:15];
    endfunction

    // x / 5 for x < 1280: reciprocal 6554 / 2^15
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = {13'd0, x} * 24'd6554;
        return p[22:15];
    endfunction

endpackage

// File: rtl/bcd_front.sv
// Front end: format register, request acceptance and classification.
// Depends on bcd_pkg.
module bcd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          block_format,
    input  logic                start,
    output logic                busy,
    input  logic [63:0]         block_first,
    input  logic [63:0]         block_second,
    input  logic                queue_full,
    output logic                push,
    output bcd_pkg::bcd_entry_t push_data
);
    import bcd_pkg::*;

    logic [1:0] format_reg;

    // Format register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_BC1;
        end
        else if (cfg_valid)
        begin
            format_reg <= block_format;
        end
    end

    // Request taken whenever the queue has room
    assign busy = queue_full;
    assign push = start && !queue_full;

    // Pick colour and alpha words by format
    always_comb
    begin
        unique case (format_reg)
            FMT_BC2:
            begin
                push_data.colour_word = block_second;
                push_data.alpha_word  = block_first;
                push_data.alpha_mode  = ALPHA_EXPLICIT;
            end
            FMT_BC3:
            begin
                push_data.colour_word = block_second;
                push_data.alpha_word  = block_first;
                push_data.alpha_mode  = ALPHA_INTERP;
            end
            default:
            begin
                push_data.colour_word = block_first;
                push_data.alpha_word  = block_second;
                push_data.alpha_mode  = ALPHA_NONE;
            end
        endcase
    end

endmodule

// File: rtl/bcd_fifo.sv
// Short request queue between front end and palette unit.
// Depends on bcd_pkg; DEPTH must be a power of two, at least 2.
module bcd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bcd_pkg::bcd_entry_t push_data,
    output logic                full,
    output logic                not_empty,
    input  logic                pop,
    output bcd_pkg::bcd_entry_t pop_data
);
    import bcd_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    bcd_entry_t         mem [DEPTH];
    logic [ADDR_W-1:0]  wr_ptr_reg;
    logic [ADDR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/bcd_palette.sv
// Palette unit: endpoint expansion and numerators, then constant divides.
// Two-stage pipeline with valid/ready; depends on bcd_pkg.
module bcd_palette (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bcd_pkg::bcd_entry_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bcd_pkg::bcd_pal_t   out_data
);
    import bcd_pkg::*;

    logic     s1_valid_reg;
    logic     s2_valid_reg;
    logic     s1_ready;
    logic     s2_ready;
    bcd_num_t s1_reg;
    bcd_num_t s1_next;
    bcd_pal_t s2_reg;
    bcd_pal_t s2_next;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

    // Stage 1: expand endpoints, form sums for interpolated entries
    always_comb
    begin
        logic [15:0] n0;
        logic [15:0] n1;
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [10:0] w0;
        logic [10:0] w1;
        n0 = in_data.colour_word[15:0];
        n1 = in_data.colour_word[31:16];
        a0 = in_data.alpha_word[7:0];
        a1 = in_data.alpha_word[15:8];
        w0 = '0;
        w1 = '0;
        s1_next.c0          = expand565(n0);
        s1_next.c1          = expand565(n1);
        s1_next.four_col    = (n0 > n1);
        s1_next.col_idx     = in_data.colour_word[63:32];
        s1_next.alpha_mode  = in_data.alpha_mode;
        s1_next.alpha_word  = in_data.alpha_word;
        s1_next.eight_alpha = (a0 > a1);
        for (int ch = 0; ch < 3; ch++)
        begin
            if (s1_next.four_col)
            begin
                s1_next.c2_num[ch] = {1'b0, s1_next.c0[ch], 1'b0}
                                   + {2'b00, s1_next.c1[ch]} + 10'd1;
                s1_next.c3_num[ch] = {1'b0, s1_next.c1[ch], 1'b0}
                                   + {2'b00, s1_next.c0[ch]} + 10'd1;
            end
            else
            begin
                s1_next.c2_num[ch] = {2'b00, s1_next.c0[ch]} + {2'b00, s1_next.c1[ch]};
                s1_next.c3_num[ch] = '0;
            end
        end
        for (int k = 1; k <= 6; k++)
        begin
            if (s1_next.eight_alpha)
            begin
                w0 = 11'(7 - k);
                w1 = 11'(k);
                s1_next.a_num[k-1] = w0 * {3'b000, a0} + w1 * {3'b000, a1} + 11'd3;
            end
            else if (k <= 4)
            begin
                w0 = 11'(5 - k);
                w1 = 11'(k);
                s1_next.a_num[k-1] = w0 * {3'b000, a0} + w1 * {3'b000, a1} + 11'd2;
            end
            else
            begin
                s1_next.a_num[k-1] = '0;
            end
        end
    end

    // Stage 2: divide numerators and assemble palettes
    always_comb
    begin
        s2_next.col_idx    = s1_reg.col_idx;
        s2_next.alpha_mode = s1_reg.alpha_mode;
        s2_next.alpha_word = s1_reg.alpha_word;
        s2_next.col_pal[0] = {ALPHA_OPAQUE, s1_reg.c0};
        s2_next.col_pal[1] = {ALPHA_OPAQUE, s1_reg.c1};
        if (s1_reg.four_col)
        begin
            s2_next.col_pal[2] = {ALPHA_OPAQUE, div3(s1_reg.c2_num[2]),
                                  div3(s1_reg.c2_num[1]), div3(s1_reg.c2_num[0])};
            s2_next.col_pal[3] = {ALPHA_OPAQUE, div3(s1_reg.c3_num[2]),
                                  div3(s1_reg.c3_num[1]), div3(s1_reg.c3_num[0])};
        end
        else
        begin
            // midpoint, and transparent black
            s2_next.col_pal[2] = {ALPHA_OPAQUE, s1_reg.c2_num[2][8:1],
                                  s1_reg.c2_num[1][8:1], s1_reg.c2_num[0][8:1]};
            s2_next.col_pal[3] = '0;
        end
        s2_next.alpha_pal[0] = s1_reg.alpha_word[7:0];
        s2_next.alpha_pal[1] = s1_reg.alpha_word[15:8];
        for (int k = 1; k <= 6; k++)
        begin
            if (s1_reg.eight_alpha)
            begin
                s2_next.alpha_pal[k+1] = div7(s1_reg.a_num[k-1]);
            end
            else if (k <= 4)
            begin
                s2_next.alpha_pal[k+1] = div5(s1_reg.a_num[k-1]);
            end
            else if (k == 5)
            begin
                s2_next.alpha_pal[k+1] = 8'h00;
            end
            else
            begin
                s2_next.alpha_pal[k+1] = 8'hFF;
            end
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

// File: rtl/bcd_emit.sv
// Texel emitter: holds one block's palettes and sends 16 texels, one a cycle.
// Depends on bcd_pkg.
module bcd_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bcd_pkg::bcd_pal_t in_data,
    output logic              pixel_valid,
    output logic [31:0]       pixel,
    output logic [3:0]        pixel_index,
    output logic              last_pixel
);
    import bcd_pkg::*;

    bcd_pal_t    blk_reg;
    logic        active_reg;
    logic [3:0]  cnt_reg;
    logic        on_last;
    logic        load;
    logic [31:0] pixel_next;
    logic        valid_reg;
    logic [31:0] pixel_reg;
    logic [3:0]  index_reg;
    logic        last_reg;

    // Next block loads as the current one sends its last texel
    assign on_last  = (cnt_reg == 4'(LAST_TEXEL));
    assign in_ready = !active_reg || on_last;
    assign load     = in_valid && in_ready;

    // Texel lookup for the current count
    always_comb
    begin
        logic [1:0]  csel;
        logic [5:0]  a_off;
        logic [47:0] a_bits;
        logic [2:0]  asel;
        logic [3:0]  a4;
        csel   = blk_reg.col_idx[{cnt_reg, 1'b0} +: 2];
        a_off  = {2'b00, cnt_reg} + {1'b0, cnt_reg, 1'b0};
        a_bits = blk_reg.alpha_word[63:16];
        asel   = a_bits[a_off +: 3];
        a4     = blk_reg.alpha_word[{cnt_reg, 2'b00} +: 4];
        pixel_next = blk_reg.col_pal[csel];
        unique case (blk_reg.alpha_mode)
            ALPHA_EXPLICIT: pixel_next[31:24] = {a4, a4};
            ALPHA_INTERP:   pixel_next[31:24] = blk_reg.alpha_pal[asel];
            default:        pixel_next[31:24] = blk_reg.col_pal[csel][31:24];
        endcase
    end

    // Texel counter and output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= active_reg;
            if (load)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                active_reg <= !on_last;
                cnt_reg    <= cnt_reg + 1'b1;
            end
        end
    end

    // Block palettes and output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            blk_reg <= in_data;
        end
        pixel_reg <= pixel_next;
        index_reg <= cnt_reg;
        last_reg  <= on_last;
    end

    assign pixel_valid = valid_reg;
    assign pixel       = pixel_reg;
    assign pixel_index = index_reg;
    assign last_pixel  = valid_reg && last_reg;

endmodule

// File: rtl/bc1_bc2_bc3_block_decoder.sv
// Channel    Handshake                   Payload
// cfg        cfg_valid / cfg_ready       block_format (2b)
// block in   start / busy                block_first, block_second (64b each)
// texel out  pixel_valid (strobe)        pixel (32b), pixel_index (4b), last_pixel
//
// Each block yields 16 texels on consecutive cycles; sustained block throughput is
// set by the one-texel-wide output. A block passes through the queue, the two
// palette stages and the emitter's block and output registers before its first texel.
// Blocks are taken while busy is low; busy rises only when the queue is full.
// rst_n clears control state and sets the format to BC1. Output cannot stall.
//
// Top level of the BC1/BC2/BC3 decoder; depends on bcd_pkg, bcd_front,
// bcd_fifo, bcd_palette and bcd_emit.
module bc1_bc2_bc3_block_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  block_format,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] block_first,
    input  logic [63:0] block_second,
    output logic        pixel_valid,
    output logic [31:0] pixel,
    output logic [3:0]  pixel_index,
    output logic        last_pixel
);
    import bcd_pkg::*;

    bcd_entry_t push_data;
    bcd_entry_t pop_data;
    bcd_pal_t   pal_data;
    logic       push;
    logic       queue_full;
    logic       queue_not_empty;
    logic       pop;
    logic       pal_in_ready;
    logic       pal_valid;
    logic       pal_ready;

    // Accept and classify
    bcd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .block_format (block_format),
        .start        (start),
        .busy         (busy),
        .block_first  (block_first),
        .block_second (block_second),
        .queue_full   (queue_full),
        .push         (push),
        .push_data    (push_data)
    );

    // Request queue
    bcd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    // Pop only a request that is there
    assign pop = queue_not_empty && pal_in_ready;

    // Palette build
    bcd_palette u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_not_empty),
        .in_ready  (pal_in_ready),
        .in_data   (pop_data),
        .out_valid (pal_valid),
        .out_ready (pal_ready),
        .out_data  (pal_data)
    );

    // Texel output
    bcd_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pal_valid),
        .in_ready    (pal_ready),
        .in_data     (pal_data),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .pixel_index (pixel_index),
        .last_pixel  (last_pixel)
    );

endmodule

// File: rtl/bcd_checker.sv
// Port-level checks for the BC1/BC2/BC3 decoder, bound to the top level.
// Depends only on the top level's ports.
module bcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        pixel_valid,
    input logic [3:0]  pixel_index,
    input logic        last_pixel
);

    // Texels of a block come out back to back in index order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && (pixel_index != 4'd15)
        |=> pixel_valid && (pixel_index == $past(pixel_index) + 4'd1))
        else $error("texel sequence broken inside a block");

    // A block starts at texel zero
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !$past(pixel_valid) |-> (pixel_index == 4'd0))
        else $error("block did not start at texel zero");

    // Last marker only on texel fifteen
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (last_pixel == (pixel_valid && (pixel_index == 4'd15))))
        else $error("last_pixel mismatch");

    // Format register never refuses a write request
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config request stalled");

endmodule

bind bc1_bc2_bc3_block_decoder bcd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .pixel_valid (pixel_valid),
    .pixel_index (pixel_index),
    .last_pixel  (last_pixel)
);

// File: dv/bc1_bc2_bc3_block_decoder_tb.sv
// Self-checking testbench for bc1_bc2_bc3_block_decoder: directed and random blocks
// in every format, texels checked against an in-bench decode. Needs rtl/bcd_pkg.sv
// and the decoder RTL.
`timescale 1ns / 100ps

module bc1_bc2_bc3_block_decoder_tb;
    import bcd_pkg::*;

    // Format code 3 has no name in the package; it decodes as BC1
    localparam logic [1:0] FMT_SPARE = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASES = 8;
    localparam int unsigned PHASE_BLOCKS = 19;
    // 3-bit alpha indexes 0..7, twice over
    localparam logic [47:0] ALPHA_RAMP = 48'hFAC688_FAC688;

    // Expected texels per accepted block, checked in arrival order
    class texel_scoreboard;
        typedef struct {
            logic [31:0] pixel;
            logic [3:0]  index;
            logic        last;
        } texel_t;

        texel_t      texels_due[$];
        logic [31:0] texel_buf[16];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return texels_due.size();
        endfunction

        function logic [31:0] opaque(input int unsigned r, input int unsigned g,
                                     input int unsigned b);
            return {8'hFF, b[7:0], g[7:0], r[7:0]};
        endfunction

        // 565 endpoint to 8-bit channels by replicating the top bits
        function void unpack565(input logic [15:0] n, output int unsigned r,
                                output int unsigned g, output int unsigned b);
            int unsigned rr, gg, bb;
            rr = (n & 16'hF800) >> 8;
            gg = (n & 16'h07E0) >> 3;
            bb = (n & 16'h001F) << 3;
            r = (rr | (rr >> 5)) & 8'hFF;
            g = (gg | (gg >> 6)) & 8'hFF;
            b = (bb | (bb >> 5)) & 8'hFF;
        endfunction

        // Colour half: four-colour palette when n0 > n1, else three colours + black
        function void decode_colour(input logic [63:0] word);
            logic [15:0] n0, n1;
            int unsigned r0, g0, b0, r1, g1, b1;
            logic [31:0] pal[4];
            n0 = word[15:0];
            n1 = word[31:16];
            unpack565(n0, r0, g0, b0);
            unpack565(n1, r1, g1, b1);
            pal[0] = opaque(r0, g0, b0);
            pal[1] = opaque(r1, g1, b1);
            if (n0 > n1)
            begin
                pal[2] = opaque((2 * r0 + r1 + 1) / 3, (2 * g0 + g1 + 1) / 3,
                                (2 * b0 + b1 + 1) / 3);
                pal[3] = opaque((2 * r1 + r0 + 1) / 3, (2 * g1 + g0 + 1) / 3,
                                (2 * b1 + b0 + 1) / 3);
            end
            else
            begin
                pal[2] = opaque((r0 + r1) / 2, (g0 + g1) / 2, (b0 + b1) / 2);
                pal[3] = 32'h0;
            end
            for (int i = 0; i < 16; i++)
                texel_buf[i] = pal[word[32 + 2 * i +: 2]];
        endfunction

        // BC2 alpha: 4 bits per texel, nibble replicated
        function void apply_explicit_alpha(input logic [63:0] word);
            logic [3:0] a4;
            for (int i = 0; i < 16; i++)
            begin
                a4 = word[4 * i +: 4];
                texel_buf[i] = {a4, a4, texel_buf[i][23:0]};
            end
        endfunction

        // BC3 alpha: 8-entry ramp when a0 > a1, else 6-entry ramp plus 0 and 255
        function void apply_ramp_alpha(input logic [63:0] word);
            int unsigned a0, a1, apal[8];
            logic [2:0] sel;
            a0 = word[7:0];
            a1 = word[15:8];
            apal[0] = a0;
            apal[1] = a1;
            if (a0 > a1)
            begin
                for (int k = 1; k <= 6; k++)
                    apal[k + 1] = ((7 - k) * a0 + k * a1 + 3) / 7;
            end
            else
            begin
                for (int k = 1; k <= 4; k++)
                    apal[k + 1] = ((5 - k) * a0 + k * a1 + 2) / 5;
                apal[6] = 0;
                apal[7] = 255;
            end
            for (int i = 0; i < 16; i++)
            begin
                sel = word[16 + 3 * i +: 3];
                texel_buf[i] = {apal[sel][7:0], texel_buf[i][23:0]};
            end
        endfunction

        function void note_block(input logic [1:0] fmt, input logic [63:0] first,
                                 input logic [63:0] second);
            texel_t t;
            case (fmt)
                FMT_BC2:
                begin
                    decode_colour(second);
                    apply_explicit_alpha(first);
                end
                FMT_BC3:
                begin
                    decode_colour(second);
                    apply_ramp_alpha(first);
                end
                default: decode_colour(first);
            endcase
            for (int i = 0; i < 16; i++)
            begin
                t.pixel = texel_buf[i];
                t.index = 4'(i);
                t.last  = (i == LAST_TEXEL);
                texels_due.push_back(t);
            end
        endfunction

        function void check_texel(input logic [31:0] pixel, input logic [3:0] index,
                                  input logic last);
            texel_t want;
            if (texels_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: texel with none pending: pixel=%h index=%0d last=%b",
                             $realtime, pixel, index, last);
                mismatches++;
                return;
            end
            want = texels_due.pop_front();
            if (want.pixel !== pixel || want.index !== index || want.last !== last)
            begin
                if (mismatches < 10)
                    $display("%0t: texel mismatch: want pixel=%h index=%0d last=%b, got pixel=%h index=%0d last=%b",
                             $realtime, want.pixel, want.index, want.last, pixel, index, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  block_format = 2'd0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] block_first = 64'd0;
    logic [63:0] block_second = 64'd0;
    logic        pixel_valid;
    logic [31:0] pixel;
    logic [3:0]  pixel_index;
    logic        last_pixel;

    texel_scoreboard sb = new();
    logic [1:0]      fmt_now = FMT_BC1;
    logic [1:0]      phase_fmt[PHASES] = '{FMT_BC1, FMT_BC3, FMT_BC2, FMT_SPARE,
                                           FMT_BC3, FMT_BC2, FMT_BC1, FMT_BC3};

    bc1_bc2_bc3_block_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .block_format(block_format),
        .start       (start),
        .busy        (busy),
        .block_first (block_first),
        .block_second(block_second),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .pixel_index (pixel_index),
        .last_pixel  (last_pixel)
    );

    always #1 clk = ~clk;

    // Texel monitor; results cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && pixel_valid)
            sb.check_texel(pixel, pixel_index, last_pixel);
    end

    // Format write; the data port is scrambled afterwards, only the register counts
    task automatic write_format(input logic [1:0] fmt);
        cfg_valid    <= 1'b1;
        block_format <= fmt;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        block_format <= 2'($urandom);
        fmt_now = fmt;
    endtask

    // One block request, held until taken
    task automatic send_block(input logic [63:0] first, input logic [63:0] second);
        start        <= 1'b1;
        block_first  <= first;
        block_second <= second;
        do @(posedge clk); while (busy);
        sb.note_block(fmt_now, first, second);
    endtask

    task automatic idle_gap(input int unsigned cycles);
        if (cycles > 0)
        begin
            start        <= 1'b0;
            block_first  <= {$urandom, $urandom};
            block_second <= {$urandom, $urandom};
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every texel is back
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Colour word with endpoint order biased toward each palette mode
    function automatic logic [63:0] rand_colour_word();
        logic [63:0] w;
        logic [15:0] n0, n1, tmp;
        w  = {$urandom, $urandom};
        n0 = w[15:0];
        n1 = w[31:16];
        case ($urandom_range(0, 5))
            0: n1 = n0;
            1: if (n0 < n1) begin tmp = n0; n0 = n1; n1 = tmp; end
            2: if (n0 > n1) begin tmp = n0; n0 = n1; n1 = tmp; end
            3: begin n0 = 16'hFFFF; n1 = 16'h0000; end
            default: ;
        endcase
        return {w[63:32], n1, n0};
    endfunction

    // Alpha word; endpoints biased toward equal and extreme values
    function automatic logic [63:0] rand_alpha_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: w[15:8] = w[7:0];
            1: w[15:0] = 16'h00FF;
            2: w[15:0] = 16'hFF00;
            default: ;
        endcase
        return w;
    endfunction

    // Stimulus
    initial
    begin
        logic        gaps_on;
        logic [63:0] first, second;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // BC1: equal endpoints, both orders, extreme endpoints, all indexes
        write_format(FMT_BC1);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block({32'hE4E4_E4E4, 16'h07E0, 16'hF800}, 64'h0);
        send_block({32'h1B1B_1B1B, 16'hFFFF, 16'h001F}, '1);
        send_block({32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'h0);
        send_block({32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, '1);
        drain();

        // Spare format code decodes as BC1
        write_format(FMT_SPARE);
        send_block({32'hE4E4_E4E4, 16'h1234, 16'h4321}, '1);
        drain();

        // BC2: alpha nibbles 0..F, black texel in three-colour mode keeps its alpha
        write_format(FMT_BC2);
        send_block(64'hFEDC_BA98_7654_3210, {32'hE4E4_E4E4, 16'h07E0, 16'hF800});
        send_block(64'h0123_4567_89AB_CDEF, {32'hE4E4_E4E4, 16'hFFFF, 16'h001F});
        send_block('1, '1);
        send_block(64'h0, 64'h0);
        drain();

        // BC3: eight- and six-entry alpha ramps with every index, equal endpoints
        write_format(FMT_BC3);
        send_block({ALPHA_RAMP, 8'h00, 8'hFF}, {32'hE4E4_E4E4, 16'h07E0, 16'hF800});
        send_block({ALPHA_RAMP, 8'hFF, 8'h00}, {32'hE4E4_E4E4, 16'hFFFF, 16'h001F});
        send_block({ALPHA_RAMP, 8'h80, 8'h80}, {32'hE4E4_E4E4, 16'h8410, 16'h8410});
        send_block({ALPHA_RAMP, 8'h05, 8'hB7}, {32'h1B1B_1B1B, 16'h001F, 16'hF81F});
        send_block({ALPHA_RAMP, 8'hB7, 8'h05}, {32'h1B1B_1B1B, 16'hF81F, 16'h001F});
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        drain();

        // Random phases, one format each
        for (int p = 0; p < PHASES; p++)
        begin
            write_format(phase_fmt[p]);
            gaps_on = (p != 2);
            for (int n = 0; n < PHASE_BLOCKS; n++)
            begin
                if (fmt_now == FMT_BC2 || fmt_now == FMT_BC3)
                begin
                    first  = rand_alpha_word();
                    second = rand_colour_word();
                end
                else
                begin
                    first  = rand_colour_word();
                    second = {$urandom, $urandom};
                end
                send_block(first, second);
                if (p == 4 && n == PHASE_BLOCKS / 2)
                    drain();
                else if (gaps_on)
                    idle_gap(pick_gap());
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit
    initial
    begin
        #200000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
